// ----- hw/rtl/mss_pkg.sv -----
// Shared types and constants for the maximum-sum submatrix core.
// No dependencies; imported by mss_scan and the top level.
package mss_pkg;

  localparam int VALUE_W = 16;  // matrix element width, signed
  localparam int OUT_W   = 23;  // result width, unsigned
  localparam int CNT_W   = 5;   // row/column count register width

  localparam int CNT_RESET = 16;

  // Configuration register indexes
  localparam logic [0:0] REG_ROW_COUNT = 1'b0;
  localparam logic [0:0] REG_COL_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Scan engine status back to the top level
  typedef struct packed {
    logic             done;
    logic [OUT_W-1:0] best;
  } scan_status_t;

endpackage

// ----- hw/rtl/mss_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first on a same-address collision. No dependencies.
module mss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/mss_scan.sv -----
// Strip scan engine: walks every left/right column pair, accumulates strip row
// sums in a RAM and runs Kadane down the rows. Depends on mss_pkg and mss_ram.
module mss_scan #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  input  logic [$clog2(MAX_ROWS+1)-1:0]              rows,
  input  logic [$clog2(MAX_COLS+1)-1:0]              cols,
  output logic [(MAX_ROWS*MAX_COLS > 1 ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] mat_raddr,
  input  logic [mss_pkg::VALUE_W-1:0]                mat_rdata,
  output mss_pkg::scan_status_t                      status
);
  import mss_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ACC_W = VALUE_W + $clog2(DEPTH) + 1;

  // Issue stage
  logic           busy;
  logic [RIW-1:0] row;
  logic [CIW-1:0] left;
  logic [CIW-1:0] right;
  logic [AW-1:0]  addr;
  logic           last_row;
  logic           last_col;
  logic           last_left;

  // Accumulate stage
  logic                    s1_valid;
  logic [RIW-1:0]          s1_row;
  logic                    s1_first;
  logic                    s1_last;
  logic                    s1_fresh;
  logic                    s1_final;
  logic signed [ACC_W-1:0] s1_new;
  logic signed [ACC_W-1:0] elem_ext;
  logic signed [ACC_W-1:0] strip_rdata;
  logic signed [ACC_W-1:0] strip_cur;
  logic                    fwd_hit;
  logic signed [ACC_W-1:0] fwd_data;

  // Kadane stage
  logic                    s2_valid;
  logic signed [ACC_W-1:0] s2_new;
  logic                    s2_first;
  logic                    s2_last;
  logic                    s2_final;
  logic signed [ACC_W-1:0] run;
  logic signed [ACC_W-1:0] top;
  logic signed [ACC_W-1:0] best;
  logic signed [ACC_W-1:0] run_in;
  logic signed [ACC_W-1:0] top_in;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] top_new;
  logic signed [ACC_W-1:0] best_next;
  logic                    done;
  logic [OUT_W-1:0]        best_sat;

  assign last_row  = (RW'(row) == rows - RW'(1));
  assign last_col  = (CW'(right) == cols - CW'(1));
  assign last_left = (CW'(left) == cols - CW'(1));
  assign mat_raddr = addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && last_row && last_col && last_left) begin
      busy <= 1'b0;
    end
  end

  // Row-major address of (row, right) advances by cols per row
  always_ff @(posedge clk) begin
    if (start) begin
      row   <= '0;
      left  <= '0;
      right <= '0;
      addr  <= '0;
    end else if (busy) begin
      if (last_row) begin
        row <= '0;
        if (last_col) begin
          left  <= left + CIW'(1);
          right <= left + CIW'(1);
          addr  <= AW'(left) + AW'(1);
        end else begin
          right <= right + CIW'(1);
          addr  <= AW'(right) + AW'(1);
        end
      end else begin
        row  <= row + RIW'(1);
        addr <= addr + AW'(cols);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_row   <= row;
    s1_first <= (row == '0);
    s1_last  <= last_row;
    s1_fresh <= (left == right);
    s1_final <= last_left;
  end

  mss_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_ROWS)
  ) u_strip_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_row),
    .wdata (s1_new),
    .raddr (row),
    .rdata (strip_rdata)
  );

  // With a single row the next pass reads the entry being written: bypass it
  always_ff @(posedge clk) begin
    fwd_hit  <= s1_valid && (s1_row == row);
    fwd_data <= s1_new;
  end

  assign elem_ext  = {{(ACC_W-VALUE_W){mat_rdata[VALUE_W-1]}}, mat_rdata};
  assign strip_cur = fwd_hit ? fwd_data : strip_rdata;
  // First column of a strip starts the row sums over
  assign s1_new    = s1_fresh ? elem_ext : strip_cur + elem_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_new   <= s1_new;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_final <= s1_final;
  end

  always_comb begin
    run_in    = s2_first ? '0 : run;
    top_in    = s2_first ? '0 : top;
    sum       = run_in + s2_new;
    top_new   = (sum > top_in) ? sum : top_in;
    best_next = (s2_last && (top_new > best)) ? top_new : best;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      best <= '0;
    end else if (s2_valid) begin
      run  <= (sum < 0) ? '0 : sum;
      top  <= top_new;
      best <= best_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid && s2_last && s2_final;
    end
  end

  // best is never negative; clip to the output range
  generate
    if (ACC_W - 1 > OUT_W) begin : g_sat
      assign best_sat = (|best[ACC_W-2:OUT_W]) ? {OUT_W{1'b1}} : best[OUT_W-1:0];
    end else begin : g_ext
      assign best_sat = OUT_W'(best[ACC_W-2:0]);
    end
  endgenerate

  assign status.done = done;
  assign status.best = best_sat;

endmodule

// ----- hw/rtl/max_sum_submatrix_core.sv -----
// Top level of the maximum-sum submatrix core: config registers, matrix load,
// result register. Depends on mss_pkg, mss_ram and mss_scan.
//
//  channel  | signals                       | direction
//  ---------+-------------------------------+-----------------------------
//  input    | in_valid, in_stall, value     | one matrix element, row-major
//  output   | out_valid, out_stall, max_sum | one sum per full matrix
//  config   | cfg_write, cfg_index, cfg_data| row_count (0), col_count (1)
//
// Loading takes one element per cycle while in_stall is low. After the last
// element the strip scan issues one matrix RAM read per row per column pair,
// then the pipeline drains and the result is handed off; input is stalled
// meanwhile. Reset sets both counts to 16 and restarts loading. A stalled
// result sits in the output register while the next matrix loads.
module max_sum_submatrix_core #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [0:0]                     cfg_index,
  input  logic [mss_pkg::CNT_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [mss_pkg::VALUE_W-1:0] value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mss_pkg::OUT_W-1:0]      max_sum
);
  import mss_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] col_count;
  logic [RW-1:0]    rows_eff;
  logic [CW-1:0]    cols_eff;
  logic [TW-1:0]    total;
  logic [TW-1:0]    load_count;
  logic [TW-1:0]    load_idx;
  logic             in_accept;
  logic             last_elem;
  logic             out_free;

  state_t state;
  state_t state_next;

  logic [AW-1:0]      mat_raddr;
  logic [VALUE_W-1:0] mat_rdata;
  scan_status_t       status;

  // A count of zero acts as one; anything above the array size is clipped
  always_comb begin
    if (row_count == '0) begin
      rows_eff = RW'(1);
    end else if (int'(row_count) > MAX_ROWS) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(row_count);
    end
    if (col_count == '0) begin
      cols_eff = CW'(1);
    end else if (int'(col_count) > MAX_COLS) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(col_count);
    end
  end

  assign total     = TW'(rows_eff) * TW'(cols_eff);
  assign load_idx  = (load_count >= total) ? '0 : load_count;
  assign in_accept = in_valid && !in_stall;
  assign last_elem = (load_idx + TW'(1) == total);
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= CNT_W'(CNT_RESET);
      col_count <= CNT_W'(CNT_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROW_COUNT: row_count <= cfg_data;
        REG_COL_COUNT: col_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Any register write restarts the matrix load
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      load_count <= '0;
    end else if (in_accept) begin
      load_count <= last_elem ? '0 : load_idx + TW'(1);
    end
  end

  mss_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_matrix_ram (
    .clk   (clk),
    .we    (in_accept),
    .waddr (load_idx[AW-1:0]),
    .wdata (value),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  mss_scan #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (in_accept && last_elem),
    .rows      (rows_eff),
    .cols      (cols_eff),
    .mat_raddr (mat_raddr),
    .mat_rdata (mat_rdata),
    .status    (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid && last_elem) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold until the output register can take the sum
        if (out_free) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      max_sum <= status.best;
    end
  end

endmodule

// ----- verif/max_sum_submatrix_core_test.sv -----
// Self-checking testbench for max_sum_submatrix_core: loads matrices, predicts the best
// contiguous submatrix sum with its own 2-D Kadane scan and checks every result.
// Depends on mss_pkg and the max_sum_submatrix_core RTL.
module max_sum_submatrix_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mss_pkg::*;

  localparam int ROWS_LIM     = 16;
  localparam int COLS_LIM     = 16;
  localparam int RANDOM_ITEMS = 1000;
  localparam int SETTLE_CYC   = 16;
  localparam int LIMIT_CYC    = 800000;
  localparam longint SUM_CEIL = 64'd8388607;

  typedef enum int {
    FILL_FULL,
    FILL_SMALL,
    FILL_NEG,
    FILL_POS,
    FILL_EXTREME
  } fill_t;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_RUNS
  } stall_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [0:0]                 cfg_index = '0;
  logic [CNT_W-1:0]           cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [VALUE_W-1:0]  value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [OUT_W-1:0]           max_sum;

  // Predictor state
  logic [CNT_W-1:0]          row_reg = CNT_W'(CNT_RESET);
  logic [CNT_W-1:0]          col_reg = CNT_W'(CNT_RESET);
  logic signed [VALUE_W-1:0] elems [ROWS_LIM*COLS_LIM];
  int                        loaded = 0;
  logic [OUT_W-1:0]          expected_sums [$];

  int mismatches = 0;
  int items_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;

  max_sum_submatrix_core #(
    .MAX_ROWS(ROWS_LIM),
    .MAX_COLS(COLS_LIM)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .value    (value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .max_sum  (max_sum)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYC) begin
      $display("timeout after %0d cycles, %0d sums outstanding", cycle_count,
               expected_sums.size());
      $display("max_sum_submatrix_core_test NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int eff_count(logic [CNT_W-1:0] c, int lim);
    if (c == 0) return 1;
    if (int'(c) > lim) return lim;
    return int'(c);
  endfunction

  function automatic logic [OUT_W-1:0] best_submatrix(int rows, int cols);
    longint strip [ROWS_LIM];
    longint best;
    longint run;
    best = 0;
    for (int left = 0; left < cols; left++) begin
      for (int r = 0; r < ROWS_LIM; r++) strip[r] = 0;
      for (int right = left; right < cols; right++) begin
        run = 0;
        for (int r = 0; r < rows; r++) begin
          strip[r] += longint'(elems[r*cols + right]);
          run += strip[r];
          if (run > best) best = run;
          if (run < 0) run = 0;
        end
      end
    end
    if (best > SUM_CEIL) best = SUM_CEIL;
    return OUT_W'(best);
  endfunction

  task automatic model_accept(input logic signed [VALUE_W-1:0] v);
    int rows;
    int cols;
    rows = eff_count(row_reg, ROWS_LIM);
    cols = eff_count(col_reg, COLS_LIM);
    if (loaded >= rows*cols) loaded = 0;
    elems[loaded] = v;
    loaded++;
    if (loaded == rows*cols) begin
      loaded = 0;
      expected_sums = {expected_sums, best_submatrix(rows, cols)};
    end
  endtask

  // ---------------------------------------------------------------- drivers

  task automatic write_count(input logic [0:0] idx, input logic [CNT_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_ROW_COUNT) row_reg = data;
    else col_reg = data;
    loaded = 0;
    @(negedge clk);
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_value(input logic signed [VALUE_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_accept(v);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid, wait for every pending sum, then let the core return to loading.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // Receiver: stall pattern that switches between never, random and long runs.
  stall_t stall_mode = STALL_NONE;
  int     mode_left = 0;
  int     run_left = 0;
  logic   run_level = 1'b0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_t'($urandom_range(0, 2));
      mode_left  = $urandom_range(40, 300);
    end else begin
      mode_left--;
    end
    if (run_left == 0) begin
      run_left  = $urandom_range(1, 20);
      run_level = ~run_level;
    end else begin
      run_left--;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      default:      out_stall <= run_level;
    endcase
  end

  // ---------------------------------------------------------------- checker

  task automatic note_mismatch(input string what, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s) at cycle %0d: expected %0d, got %0d", what, cycle_count,
               want, got);
  endtask

  always @(posedge clk) begin : check_sums
    logic [OUT_W-1:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        note_mismatch("unexpected result", '0, max_sum);
      end else begin
        want = expected_sums.pop_front();
        if (max_sum !== want) note_mismatch("max_sum", want, max_sum);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [VALUE_W-1:0] draw_value(fill_t mode);
    int t;
    case (mode)
      FILL_FULL:  return VALUE_W'($urandom);
      FILL_SMALL: begin
        t = $urandom_range(0, 16);
        return VALUE_W'(t - 8);
      end
      FILL_NEG: begin
        t = $urandom_range(1, 32768);
        return VALUE_W'(-t);
      end
      FILL_POS:   return VALUE_W'($urandom_range(0, 32767));
      default: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return -16'sd1;
          3:       return 16'sd1;
          default: return 16'sd0;
        endcase
      end
    endcase
  endfunction

  // Mostly small sizes; now and then zero, oversize or the full size.
  function automatic logic [CNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return CNT_W'($urandom_range(17, 31));
    if (r < 15) return CNT_W'($urandom_range(5, 16));
    if (r < 18) return CNT_W'(16);
    return CNT_W'($urandom_range(1, 4));
  endfunction

  // Full 16x16 matrix of the largest value at the reset sizes.
  task automatic test_reset_size();
    for (int i = 0; i < ROWS_LIM*COLS_LIM; i++) send_value(16'sh7fff);
    settle();
  endtask

  task automatic test_single_element();
    write_count(REG_ROW_COUNT, CNT_W'(1));
    write_count(REG_COL_COUNT, CNT_W'(1));
    send_value(16'sh7fff);
    send_value(16'sh8000);
    send_value(16'sd0);
    send_value(-16'sd1);
    send_value(16'sd1);
    settle();
  endtask

  // A count of zero behaves as one.
  task automatic test_zero_count();
    write_count(REG_ROW_COUNT, '0);
    write_count(REG_COL_COUNT, '0);
    send_value(16'sd7);
    settle();
  endtask

  task automatic test_strip_mix();
    write_count(REG_ROW_COUNT, CNT_W'(2));
    write_count(REG_COL_COUNT, CNT_W'(3));
    send_value(-16'sd5);
    send_value(16'sd4);
    send_value(16'sh8000);
    send_value(16'sd3);
    send_value(-16'sd1);
    send_value(16'sd6);
    settle();
  endtask

  // A register write in the middle of a matrix restarts the load.
  task automatic test_restart_on_write();
    write_count(REG_ROW_COUNT, CNT_W'(2));
    write_count(REG_COL_COUNT, CNT_W'(2));
    send_value(16'sh7fff);
    send_value(16'sh7fff);
    settle();
    write_count(REG_COL_COUNT, CNT_W'(2));
    send_value(-16'sd3);
    send_value(16'sd9);
    send_value(16'sd2);
    send_value(-16'sd4);
    settle();
  endtask

  task automatic test_all_negative();
    write_count(REG_ROW_COUNT, CNT_W'(1));
    write_count(REG_COL_COUNT, CNT_W'(4));
    send_value(-16'sd1);
    send_value(16'sh8000);
    send_value(-16'sd7);
    send_value(-16'sd2);
    settle();
  endtask

  task automatic test_random_matrices();
    int    start;
    int    sel;
    int    total;
    int    count;
    fill_t mode;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      settle();
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        write_count(REG_ROW_COUNT, pick_count());
        write_count(REG_COL_COUNT, pick_count());
      end else if (sel < 85) begin
        if ($urandom_range(0, 1) == 0) write_count(REG_ROW_COUNT, pick_count());
        else write_count(REG_COL_COUNT, pick_count());
      end
      mode  = fill_t'($urandom_range(0, 4));
      total = eff_count(row_reg, ROWS_LIM) * eff_count(col_reg, COLS_LIM);
      if (total > 1 && $urandom_range(0, 99) < 15) begin
        // Broken matrix: stop short and let the next phase take over.
        count = $urandom_range(1, total - 1);
      end else begin
        count = (total > 64) ? total : total * $urandom_range(1, 3);
      end
      for (int i = 0; i < count; i++) send_value(draw_value(mode));
    end
    settle();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_size();
    test_single_element();
    test_zero_count();
    test_strip_mix();
    test_restart_on_write();
    test_all_negative();
    test_random_matrices();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_sums.size() == 0) begin
      $display("max_sum_submatrix_core_test OK");
    end else begin
      $display("max_sum_submatrix_core_test NOT OK");
    end
    $finish;
  end

endmodule
